@@ design/sri_pkg.sv @@
`timescale 1ns / 1ps

package sri_pkg;

  localparam int NUM_ELEMENTS = 8;
  localparam int OUT_COUNT    = (NUM_ELEMENTS < 8) ? NUM_ELEMENTS : 8;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [16:0] HALF_Q16    = 17'h08000;
  localparam logic [31:0] EXP_M1_Q32  = 32'h5E2D58D9;
  localparam logic [63:0] PI4_Q32     = 64'h00000000C90FDAA2;
  localparam logic [31:0] INV_PI_Q32  = 32'h517CC1B7;
  localparam logic [63:0] TAN_PI8_Q32 = 64'h000000006A09E667;

  typedef enum logic [1:0] {
    CMD_GOAL  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_TANH   = 2'd1,
    MODE_ATAN   = 2'd2,
    MODE_ZERO   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_BETA     = 2'd1,
    REG_DURATION = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XDIV,
    ST_WSEL,
    ST_NUM,
    ST_DEN,
    ST_MAG,
    ST_L0,
    ST_LMUL,
    ST_LDIV,
    ST_LR,
    ST_LN,
    ST_LS,
    ST_A0,
    ST_AU,
    ST_Z2,
    ST_SDIV,
    ST_SMUL,
    ST_AF,
    ST_B0,
    ST_B1,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         element;
    logic signed [31:0] value;
    logic [31:0]        tick_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_element;
    logic signed [31:0] position;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] prod;
  } mul_rsp_t;

endpackage

@@ design/smooth_reach_interpolator.sv @@
`timescale 1ns / 1ps
// Goal and start loads are stored as they are accepted. A tick runs through a shared 64-bit
// radix-2 divider and a shared 64x32 multiplier; the tanh and atan curves need more divisions
// and products than linear mode. Each position is formed from the weight by a start product
// and a goal product, and is emitted when the output is free, one element after another.
// Reset is asynchronous and active low; it loads the register defaults and clears all stores.
module smooth_reach_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sri_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sri_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import sri_pkg::*;

  state_e      state_q, state_d;
  logic        pend_q, pend_d;
  logic [63:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, r3_q, r3_d, r4_q, r4_d;
  logic [16:0] x_q, x_d, s_q, s_d;
  logic        neg_q, neg_d, big_q, big_d, red_q, red_d;
  logic [3:0]  k_q, k_d, n_q, n_d;
  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  mode_e       mode_q;
  logic [15:0] beta_q;
  logic [15:0] dur_q;

  logic signed [31:0] goal_q  [NUM_ELEMENTS];
  logic signed [31:0] cand_q  [NUM_ELEMENTS];
  logic signed [31:0] start_q [NUM_ELEMENTS];
  logic [31:0]        tick0_q;
  logic               arm_q;
  logic               run_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic        accept;
  logic        el_ok;
  logic        is_tick;
  logic [31:0] elapsed;
  logic [16:0] dbl;
  logic [16:0] diff;
  logic [31:0] a_log;
  logic [63:0] d_log;
  logic [63:0] series;
  logic [63:0] au;
  logic [63:0] a_atan;
  logic [63:0] f_sum;
  logic [16:0] f;
  logic [16:0] sv;
  logic [63:0] rnd;
  logic        fits;
  logic signed [31:0] pos;

  sri_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sri_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign el_ok       = ({29'd0, in_data_i.element} < NUM_ELEMENTS);
  assign is_tick     = accept && (in_data_i.command == CMD_TICK);
  assign elapsed     = arm_q ? 32'd0 : (in_data_i.tick_time - tick0_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dbl    = {x_q[15:0], 1'b0};
  assign diff   = neg_q ? (ONE_Q16 - dbl) : (dbl - ONE_Q16);
  assign a_log  = {r0_q[30:0], 1'b0};
  assign d_log  = 64'h100000000 + r1_q;
  assign series = r0_q - r4_q;
  assign au     = red_q ? (PI4_Q32 - series) : series;
  assign a_atan = big_q ? ({PI4_Q32[62:0], 1'b0} - au) : au;
  assign f_sum  = mul_rsp.prod[63:0] + 64'h0000800000000000;
  assign f      = {1'b0, f_sum[63:48]};
  assign sv     = (div_rsp.quot > {47'd0, ONE_Q16}) ? ONE_Q16 : div_rsp.quot[16:0];
  assign rnd    = r0_q + 64'd32768;
  assign fits   = (rnd[63:47] == '0) || (rnd[63:47] == '1);
  assign pos    = fits ? rnd[47:16] : (rnd[63] ? 32'sh80000000 : 32'sh7FFFFFFF);

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    r3_d        = r3_q;
    r4_d        = r4_q;
    x_d         = x_q;
    s_d         = s_q;
    neg_d       = neg_q;
    big_d       = big_q;
    red_d       = red_q;
    k_d         = k_q;
    n_d         = n_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    div_req     = '{start: 1'b0, dividend: 64'd0, divisor: 64'd1};
    mul_req     = '{start: 1'b0, a: 64'd0, b: 32'd0};

    case (state_q)
      ST_IDLE: begin
        if (is_tick && (arm_q || run_q)) begin
          r0_d    = {32'd0, elapsed};
          idx_d   = '0;
          state_d = ST_XDIV;
        end
      end

      ST_XDIV: begin
        if (dur_q == 16'd0) begin
          x_d     = ONE_Q16;
          state_d = ST_WSEL;
        end else begin
          div_req.dividend = {16'd0, r0_q[31:0], 16'd0};
          div_req.divisor  = {48'd0, dur_q};
          if (!pend_q) begin
            div_req.start = 1'b1;
            pend_d        = 1'b1;
          end else if (div_rsp.done) begin
            pend_d  = 1'b0;
            x_d     = sv;
            state_d = ST_WSEL;
          end
        end
      end

      ST_WSEL: begin
        case (mode_q)
          MODE_LINEAR: begin
            s_d     = x_q;
            state_d = ST_B0;
          end
          MODE_ZERO: begin
            s_d     = '0;
            state_d = ST_B0;
          end
          default: begin
            if (x_q == 17'd0) begin
              s_d     = '0;
              state_d = ST_B0;
            end else if (x_q == ONE_Q16) begin
              s_d     = ONE_Q16;
              state_d = ST_B0;
            end else begin
              neg_d   = (x_q < HALF_Q16);
              state_d = ST_NUM;
            end
          end
        endcase
      end

      ST_NUM: begin
        mul_req.a = {48'd0, beta_q};
        mul_req.b = {15'd0, diff};
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r0_d    = {mul_rsp.prod[39:0], 24'd0};
          state_d = ST_DEN;
        end
      end

      ST_DEN: begin
        mul_req.a = {47'd0, x_q};
        mul_req.b = {15'd0, ONE_Q16 - x_q};
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r1_d    = mul_rsp.prod[63:0];
          state_d = ST_MAG;
        end
      end

      ST_MAG: begin
        div_req.dividend = r0_q;
        div_req.divisor  = r1_q;
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (div_rsp.done) begin
          pend_d  = 1'b0;
          r0_d    = (div_rsp.quot > 64'h7FFFFFFF) ? 64'h7FFFFFFF : div_rsp.quot;
          state_d = (mode_q == MODE_TANH) ? ST_L0 : ST_A0;
        end
      end

      ST_L0: begin
        if (a_log >= 32'h000C0000) begin
          s_d     = neg_q ? 17'd0 : ONE_Q16;
          state_d = ST_B0;
        end else begin
          n_d     = a_log[19:16];
          r0_d    = {32'd0, a_log[15:0], 16'd0};
          r1_d    = 64'h100000000;
          r2_d    = 64'h100000000;
          k_d     = 4'd1;
          state_d = ST_LMUL;
        end
      end

      ST_LMUL: begin
        mul_req.a = r1_q;
        mul_req.b = r0_q[31:0];
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r1_d    = {32'd0, mul_rsp.prod[63:32]};
          state_d = ST_LDIV;
        end
      end

      ST_LDIV: begin
        div_req.dividend = r1_q;
        div_req.divisor  = {60'd0, k_q};
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (div_rsp.done) begin
          pend_d = 1'b0;
          r1_d   = div_rsp.quot;
          r2_d   = r2_q + div_rsp.quot;
          if (k_q == 4'd12) begin
            k_d     = '0;
            state_d = ST_LR;
          end else begin
            k_d     = k_q + 4'd1;
            state_d = ST_LMUL;
          end
        end
      end

      ST_LR: begin
        div_req.dividend = '1;
        div_req.divisor  = r2_q;
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (div_rsp.done) begin
          pend_d  = 1'b0;
          r1_d    = div_rsp.quot;
          state_d = ST_LN;
        end
      end

      ST_LN: begin
        if (k_q == n_q) begin
          state_d = ST_LS;
        end else begin
          mul_req.a = r1_q;
          mul_req.b = EXP_M1_Q32;
          if (!pend_q) begin
            mul_req.start = 1'b1;
            pend_d        = 1'b1;
          end else if (mul_rsp.done) begin
            pend_d = 1'b0;
            r1_d   = {32'd0, mul_rsp.prod[63:32]};
            k_d    = k_q + 4'd1;
          end
        end
      end

      ST_LS: begin
        div_req.dividend = 64'h0001000000000000 + {1'b0, d_log[63:1]};
        div_req.divisor  = d_log;
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (div_rsp.done) begin
          pend_d  = 1'b0;
          s_d     = neg_q ? (ONE_Q16 - sv) : sv;
          state_d = ST_B0;
        end
      end

      ST_A0: begin
        if (r0_q <= {47'd0, ONE_Q16}) begin
          r1_d    = {r0_q[47:0], 16'd0};
          big_d   = 1'b0;
          state_d = ST_AU;
        end else begin
          div_req.dividend = 64'h0001000000000000;
          div_req.divisor  = r0_q;
          if (!pend_q) begin
            div_req.start = 1'b1;
            pend_d        = 1'b1;
          end else if (div_rsp.done) begin
            pend_d  = 1'b0;
            r1_d    = div_rsp.quot;
            big_d   = 1'b1;
            state_d = ST_AU;
          end
        end
      end

      ST_AU: begin
        if (r1_q > TAN_PI8_Q32) begin
          div_req.dividend = {32'h0 - r1_q[31:0], 32'd0};
          div_req.divisor  = 64'h100000000 + r1_q;
          if (!pend_q) begin
            div_req.start = 1'b1;
            pend_d        = 1'b1;
          end else if (div_rsp.done) begin
            pend_d  = 1'b0;
            r2_d    = div_rsp.quot;
            red_d   = 1'b1;
            state_d = ST_Z2;
          end
        end else begin
          r2_d    = r1_q;
          red_d   = 1'b0;
          state_d = ST_Z2;
        end
      end

      ST_Z2: begin
        mul_req.a = r2_q;
        mul_req.b = r2_q[31:0];
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r3_d    = {32'd0, mul_rsp.prod[63:32]};
          r1_d    = r2_q;
          r0_d    = '0;
          r4_d    = '0;
          k_d     = '0;
          state_d = ST_SDIV;
        end
      end

      ST_SDIV: begin
        div_req.dividend = r1_q;
        div_req.divisor  = {59'd0, k_q, 1'b1};
        if (!pend_q) begin
          div_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (div_rsp.done) begin
          pend_d = 1'b0;
          if (k_q[0]) begin
            r4_d = r4_q + div_rsp.quot;
          end else begin
            r0_d = r0_q + div_rsp.quot;
          end
          state_d = (k_q == 4'd15) ? ST_AF : ST_SMUL;
        end
      end

      ST_SMUL: begin
        mul_req.a = r1_q;
        mul_req.b = r3_q[31:0];
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r1_d    = {32'd0, mul_rsp.prod[63:32]};
          k_d     = k_q + 4'd1;
          state_d = ST_SDIV;
        end
      end

      ST_AF: begin
        mul_req.a = a_atan;
        mul_req.b = INV_PI_Q32;
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          s_d     = neg_q ? (HALF_Q16 - f) : (HALF_Q16 + f);
          state_d = ST_B0;
        end
      end

      ST_B0: begin
        mul_req.a = {{32{start_q[idx_q][31]}}, start_q[idx_q]};
        mul_req.b = {15'd0, ONE_Q16 - s_q};
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r0_d    = mul_rsp.prod[63:0];
          state_d = ST_B1;
        end
      end

      ST_B1: begin
        mul_req.a = {{32{goal_q[idx_q][31]}}, goal_q[idx_q]};
        mul_req.b = {15'd0, s_q};
        if (!pend_q) begin
          mul_req.start = 1'b1;
          pend_d        = 1'b1;
        end else if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r0_d    = r0_q + mul_rsp.prod[63:0];
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.out_element = idx_q;
          out_d.position    = pos;
          out_d.last        = (idx_q == 3'(OUT_COUNT - 1));
          idx_d             = idx_q + 3'd1;
          state_d           = (idx_q == 3'(OUT_COUNT - 1)) ? ST_IDLE : ST_B0;
        end
      end

      default: begin
        state_d = ST_IDLE;
        pend_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    r3_q  <= r3_d;
    r4_q  <= r4_d;
    x_q   <= x_d;
    s_q   <= s_d;
    neg_q <= neg_d;
    big_q <= big_d;
    red_q <= red_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ATAN;
      beta_q <= 16'd307;
      dur_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:     mode_q <= mode_e'(cfg_data_i[1:0]);
        REG_BETA:     beta_q <= cfg_data_i;
        REG_DURATION: dur_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
        goal_q[i]  <= '0;
        cand_q[i]  <= '0;
        start_q[i] <= '0;
      end
      tick0_q <= '0;
      arm_q   <= 1'b1;
      run_q   <= 1'b0;
    end else if (accept) begin
      if ((in_data_i.command == CMD_GOAL) && el_ok) begin
        goal_q[in_data_i.element] <= in_data_i.value;
        arm_q                     <= 1'b1;
      end
      if ((in_data_i.command == CMD_START) && el_ok) begin
        cand_q[in_data_i.element] <= in_data_i.value;
      end
      if (is_tick && arm_q) begin
        for (int i = 0; i < NUM_ELEMENTS; i++) begin
          start_q[i] <= cand_q[i];
        end
        tick0_q <= in_data_i.tick_time;
        arm_q   <= 1'b0;
        run_q   <= 1'b1;
      end
    end
  end

endmodule

@@ design/sri_div.sv @@
`timescale 1ns / 1ps

module sri_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sri_pkg::div_req_t req_i,
  output sri_pkg::div_rsp_t rsp_o
);
  import sri_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q;
  logic [63:0] dvd_q;
  logic [63:0] dvs_q;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        qbit;

  assign trial = {rem_q, dvd_q[63]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = ~diff[64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[63:0] : trial[63:0];
      dvd_q <= {dvd_q[62:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

@@ design/sri_mul.sv @@
`timescale 1ns / 1ps

module sri_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sri_pkg::mul_req_t req_i,
  output sri_pkg::mul_rsp_t rsp_o
);
  import sri_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [1:0]  ph_q;
  logic [63:0] a_q;
  logic [31:0] b_q;
  logic [63:0] lo_q;
  logic [63:0] hi_q;
  logic [95:0] prod_q;
  logic [31:0] half;
  logic [63:0] part;

  assign half = (ph_q == 2'd0) ? a_q[31:0] : a_q[63:32];
  assign part = {32'd0, half} * {32'd0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      case (ph_q)
        2'd0:    lo_q <= part;
        2'd1:    hi_q <= part;
        default: prod_q <= {hi_q, 32'd0} + {32'd0, lo_q};
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule
